// File: src/srt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the sorted resource table
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 17;
    localparam int ID_W        = 16;
    localparam int HANDLE_W    = 32;
    localparam int LEN_W       = 24;
    localparam int POS_W       = 7;
    localparam int STAT_W      = 3;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_ID    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_BUSY      = 3'd5;
    localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 3'd6;

    localparam logic [1:0] MODE_INSTALL   = 2'd0;
    localparam logic [1:0] MODE_UNINSTALL = 2'd1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        t_key                key;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } t_cell_cmd;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT
    } t_state;

endpackage

// File: src/sorted_resource_table.sv
`timescale 1ns / 1ps
// top level: command handshake, result decode and the chain of table cells
// Each item passes through a compare cycle in which every cell of the chain
// checks its key against the searched key at once, then a shift cycle in which
// the cells move one place to open or close a slot for a successful install or
// uninstall, and the result strobe o_valid is high for that one cycle. busy is
// high only in the compare cycle, so a new item may be started in the same cycle
// as a result is shown. The receiver cannot stall; it must take each result in
// the cycle o_valid is high. No clearing is needed after reset.
module sorted_resource_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_mode,
    input  logic                           i_kind,
    input  logic [srt_pkg::ID_W-1:0]       i_res_id,
    input  logic [srt_pkg::HANDLE_W-1:0]   i_payload_handle,
    input  logic [srt_pkg::LEN_W-1:0]      i_payload_len,
    input  logic                           i_frame_busy,
    output logic                           o_valid,
    output logic [srt_pkg::STAT_W-1:0]     o_status,
    output logic [srt_pkg::HANDLE_W-1:0]   o_out_handle,
    output logic [srt_pkg::LEN_W-1:0]      o_out_len,
    output logic [srt_pkg::POS_W-1:0]      o_position
);
    import srt_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    // latched item
    logic [1:0]          r_mode;
    logic                r_kind;
    logic [ID_W-1:0]     r_id;
    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_len;
    logic                r_fbusy;

    logic [CNT_W-1:0]    r_count;
    t_op                 r_op;
    logic [CNT_W-1:0]    r_pos;
    logic [STAT_W-1:0]   r_status;
    logic [HANDLE_W-1:0] r_oh;
    logic [LEN_W-1:0]    r_ol;

    t_key      search_key;
    t_entry    new_entry;
    t_entry    cells   [TABLE_DEPTH];
    t_cell_cmd cmds    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lt;
    logic [TABLE_DEPTH-1:0] eq;

    logic                found;
    logic [CNT_W-1:0]    pos;
    logic [HANDLE_W-1:0] hit_handle;
    logic [LEN_W-1:0]    hit_len;
    t_op                 n_op;
    logic [STAT_W-1:0]   n_status;
    logic [CNT_W-1:0]    n_pos;
    logic [HANDLE_W-1:0] n_oh;
    logic [LEN_W-1:0]    n_ol;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        busy    = (r_state == S_CMP);
        o_valid = (r_state == S_SHIFT);
        accept  = start && !busy;
        unique case (r_state)
            S_IDLE:  n_state = start ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_SHIFT;
            S_SHIFT: n_state = start ? S_CMP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_kind   <= i_kind;
            r_id     <= i_res_id;
            r_handle <= i_payload_handle;
            r_len    <= i_payload_len;
            r_fbusy  <= i_frame_busy;
        end
    end

    assign search_key = {r_kind, r_id};
    assign new_entry  = '{key: search_key, handle: r_handle, len: r_len};

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        srt_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmds[g]),
            .i_valid (CNT_W'(g) < r_count),
            .i_key   (search_key),
            .i_new   (new_entry),
            .i_left  (cells[(g == 0) ? 0 : g - 1]),
            .i_right (cells[(g == TABLE_DEPTH - 1) ? g : g + 1]),
            .o_entry (cells[g]),
            .o_lt    (lt[g]),
            .o_eq    (eq[g])
        );
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cmds[i] = CELL_HOLD;
            if (r_state == S_SHIFT) begin
                if (r_op == OP_INSERT) begin
                    if (CNT_W'(i) > r_pos) begin
                        cmds[i] = CELL_LEFT;
                    end else if (CNT_W'(i) == r_pos) begin
                        cmds[i] = CELL_LOAD;
                    end
                end else if (r_op == OP_REMOVE) begin
                    if (CNT_W'(i) >= r_pos) begin
                        cmds[i] = CELL_RIGHT;
                    end
                end
            end
        end
    end

    // lt is a run of ones from cell 0; the slot is where the run ends
    always_comb begin
        pos        = '0;
        hit_handle = '0;
        hit_len    = '0;
        found      = |eq;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (((i == 0) || lt[(i == 0) ? 0 : i - 1]) && !lt[i]) begin
                pos = pos | CNT_W'(i);
            end
            if (eq[i]) begin
                hit_handle = hit_handle | cells[i].handle;
                hit_len    = hit_len | cells[i].len;
            end
        end
        if (lt[TABLE_DEPTH-1]) begin
            pos = pos | CNT_W'(TABLE_DEPTH);
        end
    end

    always_comb begin
        n_op     = OP_NONE;
        n_status = STAT_OK;
        n_pos    = '0;
        n_oh     = '0;
        n_ol     = '0;
        if (r_mode == MODE_INSTALL) begin
            priority if (r_id == '0) begin
                n_status = STAT_BAD_ID;
            end else if (r_len == '0) begin
                n_status = STAT_BAD_LEN;
            end else if (found) begin
                n_status = STAT_DUP;
                n_pos    = pos;
            end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                n_status = STAT_FULL;
                n_pos    = pos;
            end else begin
                n_op  = OP_INSERT;
                n_pos = pos;
            end
        end else if (r_mode == MODE_UNINSTALL) begin
            priority if (r_fbusy) begin
                n_status = STAT_BUSY;
            end else if (r_id == '0) begin
                n_status = STAT_BAD_ID;
            end else if (!found) begin
                n_status = STAT_NOT_FOUND;
                n_pos    = pos;
            end else begin
                n_op  = OP_REMOVE;
                n_pos = pos;
                n_oh  = hit_handle;
                n_ol  = hit_len;
            end
        end else begin
            priority if (r_id == '0) begin
                n_status = STAT_BAD_ID;
            end else if (!found) begin
                n_status = STAT_NOT_FOUND;
                n_pos    = pos;
            end else begin
                n_pos = pos;
                n_oh  = hit_handle;
                n_ol  = hit_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_NONE;
            r_count <= '0;
        end else begin
            if (r_state == S_CMP) begin
                r_op <= n_op;
            end
            if (r_state == S_SHIFT) begin
                if (r_op == OP_INSERT) begin
                    r_count <= r_count + 1'b1;
                end else if (r_op == OP_REMOVE) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_oh     <= n_oh;
            r_ol     <= n_ol;
        end
    end

    assign o_status     = r_status;
    assign o_out_handle = r_oh;
    assign o_out_len    = r_ol;
    assign o_position   = POS_W'(r_pos);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_cmp_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("compare cycle not followed by a result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_sorted_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (((lt + 1'b1) & lt) == '0))
        else $error("cell chain out of key order");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_op == OP_INSERT) |=> (r_count == $past(r_count) + 1'b1))
        else $error("install did not grow the table");

endmodule

// File: src/srt_cell.sv
`timescale 1ns / 1ps
// one slot of the sorted chain: holds an entry, compares it and shifts it
module srt_cell (
    input  logic              i_clk,
    input  srt_pkg::t_cell_cmd i_cmd,
    input  logic              i_valid,
    input  srt_pkg::t_key     i_key,
    input  srt_pkg::t_entry   i_new,
    input  srt_pkg::t_entry   i_left,
    input  srt_pkg::t_entry   i_right,
    output srt_pkg::t_entry   o_entry,
    output logic              o_lt,
    output logic              o_eq
);
    import srt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        unique case (i_cmd)
            CELL_HOLD:  n_entry = r_entry;
            CELL_LOAD:  n_entry = i_new;
            CELL_LEFT:  n_entry = i_left;
            CELL_RIGHT: n_entry = i_right;
            default:    n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // stored key below the searched key
    assign o_lt    = i_valid && (r_entry.key < i_key);
    assign o_eq    = i_valid && (r_entry.key == i_key);
    assign o_entry = r_entry;

endmodule

// File: tb/tb_sorted_resource_table.sv
`timescale 1ns / 1ps
// testbench of the sorted resource table: queued command driver, result monitor, table predictor
module tb_sorted_resource_table;
    import srt_pkg::*;

    localparam logic [1:0]      MODE_LOOKUP = 2'd2;
    localparam logic [1:0]      MODE_ALIAS  = 2'd3;
    localparam logic [ID_W-1:0] ID_MAX      = 16'hffff;
    localparam int              POOL_SIZE   = 96;
    localparam int              CYCLE_LIMIT = 300000;

    typedef struct {
        logic [1:0]          mode;
        logic                kind;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                fbusy;
        int                  gap;
        bit                  hold;
    } t_cmd;

    typedef struct {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic [POS_W-1:0]    pos;
    } t_reply;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic                busy;
    logic [1:0]          i_mode           = MODE_INSTALL;
    logic                i_kind           = 1'b0;
    logic [ID_W-1:0]     i_res_id         = '0;
    logic [HANDLE_W-1:0] i_payload_handle = '0;
    logic [LEN_W-1:0]    i_payload_len    = '0;
    logic                i_frame_busy     = 1'b0;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [LEN_W-1:0]    o_out_len;
    logic [POS_W-1:0]    o_position;

    // shadow copy of the table
    logic [KEY_W-1:0]    tbl_key    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] tbl_handle [TABLE_DEPTH];
    logic [LEN_W-1:0]    tbl_len    [TABLE_DEPTH];
    int                  tbl_count = 0;

    t_cmd   cmd_q[$];
    t_reply reply_q[$];
    int     errors = 0;
    bit     no_idle = 0;

    logic [ID_W-1:0] pool_id   [POOL_SIZE];
    logic            pool_kind [POOL_SIZE];

    sorted_resource_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_kind           (i_kind),
        .i_res_id         (i_res_id),
        .i_payload_handle (i_payload_handle),
        .i_payload_len    (i_payload_len),
        .i_frame_busy     (i_frame_busy),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_out_len        (o_out_len),
        .o_position       (o_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one command to the shadow table and returns the reply it should give
    function automatic t_reply table_apply(t_cmd c);
        t_reply           r;
        logic [KEY_W-1:0] key;
        int               p;
        int               i;
        bit               hit;
        bit               id_ok;
        r.status = STAT_OK;
        r.handle = '0;
        r.len    = '0;
        r.pos    = '0;
        key   = {c.kind, c.id};
        id_ok = (c.id != '0);
        // lower bound: match index or insertion index
        for (p = 0; p < tbl_count; p++) begin
            if (tbl_key[p] >= key) break;
        end
        hit = (p < tbl_count) && (tbl_key[p] == key);
        if (c.mode == MODE_INSTALL) begin
            if (!id_ok) r.status = STAT_BAD_ID;
            else if (c.len == '0) r.status = STAT_BAD_LEN;
            else if (hit) begin
                r.status = STAT_DUP;
                r.pos    = p[POS_W-1:0];
            end else if (tbl_count >= TABLE_DEPTH) begin
                r.status = STAT_FULL;
                r.pos    = p[POS_W-1:0];
            end else begin
                for (i = tbl_count; i > p; i--) begin
                    tbl_key[i]    = tbl_key[i-1];
                    tbl_handle[i] = tbl_handle[i-1];
                    tbl_len[i]    = tbl_len[i-1];
                end
                tbl_key[p]    = key;
                tbl_handle[p] = c.handle;
                tbl_len[p]    = c.len;
                tbl_count++;
                r.pos = p[POS_W-1:0];
            end
        end else if (c.mode == MODE_UNINSTALL) begin
            if (c.fbusy) r.status = STAT_BUSY;
            else if (!id_ok) r.status = STAT_BAD_ID;
            else if (!hit) begin
                r.status = STAT_NOT_FOUND;
                r.pos    = p[POS_W-1:0];
            end else begin
                r.handle = tbl_handle[p];
                r.len    = tbl_len[p];
                r.pos    = p[POS_W-1:0];
                for (i = p; i + 1 < tbl_count; i++) begin
                    tbl_key[i]    = tbl_key[i+1];
                    tbl_handle[i] = tbl_handle[i+1];
                    tbl_len[i]    = tbl_len[i+1];
                end
                tbl_count--;
            end
        end else begin
            // lookup, the spare mode code included
            if (!id_ok) r.status = STAT_BAD_ID;
            else if (!hit) begin
                r.status = STAT_NOT_FOUND;
                r.pos    = p[POS_W-1:0];
            end else begin
                r.handle = tbl_handle[p];
                r.len    = tbl_len[p];
                r.pos    = p[POS_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_cmd(bit hold, logic [1:0] mode, logic kind, logic [ID_W-1:0] id,
                           logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len, logic fbusy);
        t_cmd c;
        c.mode   = mode;
        c.kind   = kind;
        c.id     = id;
        c.handle = handle;
        c.len    = len;
        c.fbusy  = fbusy;
        c.gap    = pick_gap();
        c.hold   = hold;
        cmd_q.push_back(c);
    endtask

    // driver
    t_cmd cur_cmd;
    int   gap_left = 0;
    bit   gap_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left =  0;
            gap_done =  0;
        end else begin
            if (start && !busy) begin
                reply_q.push_back(table_apply(cur_cmd));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() == 0) begin
                    start <= 1'b0;
                end else if (!gap_done && cmd_q[0].gap > 0) begin
                    gap_left = cmd_q[0].gap - 1;
                    gap_done = 1;
                    start    <= 1'b0;
                end else if (cmd_q[0].hold && reply_q.size() != 0) begin
                    // hold off until the block has drained
                    start <= 1'b0;
                end else begin
                    cur_cmd  = cmd_q.pop_front();
                    gap_done = 0;
                    start            <= 1'b1;
                    i_mode           <= cur_cmd.mode;
                    i_kind           <= cur_cmd.kind;
                    i_res_id         <= cur_cmd.id;
                    i_payload_handle <= cur_cmd.handle;
                    i_payload_len    <= cur_cmd.len;
                    i_frame_busy     <= cur_cmd.fbusy;
                end
            end
        end
    end

    // monitor
    t_reply want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d handle %h len %h pos %0d",
                         $time, o_status, o_out_handle, o_out_len, o_position);
                errors++;
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_out_handle !== want.handle) begin
                    $display("%0t: handle expected %h actual %h", $time, want.handle, o_out_handle);
                    errors++;
                end
                if (o_out_len !== want.len) begin
                    $display("%0t: length expected %h actual %h", $time, want.len, o_out_len);
                    errors++;
                end
                if (o_position !== want.pos) begin
                    $display("%0t: position expected %0d actual %0d", $time, want.pos, o_position);
                    errors++;
                end
            end
        end
    end

    // watchdog
    int cycles = 0;

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int               ph;
        int               n;
        int               kind_sel;
        int               r;
        int               q;
        int               idx;
        logic [1:0]       mode;
        logic             kind;
        logic [ID_W-1:0]  id;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0] len;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_id[i]   = ID_W'($urandom_range(1, 65535));
            pool_kind[i] = 1'($urandom_range(0, 1));
        end

        // directed: empty table, bad id and length, extremes, busy and spare mode
        add_cmd(0, MODE_LOOKUP,    1'b0, 16'd5,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_UNINSTALL, 1'b0, 16'd5,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b0, 16'd0,  32'h1111,     24'd5,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b1, 16'd0,  32'h2222,     24'd0,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b0, 16'd7,  32'h3333,     24'd0,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b0, ID_MAX, 32'hffffffff, 24'hffffff,   1'b1);
        add_cmd(0, MODE_INSTALL,   1'b1, 16'd1,  32'd0,        24'd1,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b0, 16'd1,  32'h12345678, 24'hffffff,   1'b0);
        add_cmd(0, MODE_INSTALL,   1'b1, ID_MAX, 32'ha5a5a5a5, 24'h5a5a5a,   1'b0);
        add_cmd(0, MODE_INSTALL,   1'b0, ID_MAX, 32'h0badf00d, 24'h000100,   1'b0);
        add_cmd(0, MODE_LOOKUP,    1'b1, ID_MAX, 32'd0,        24'd0,        1'b1);
        add_cmd(0, MODE_ALIAS,     1'b0, 16'd1,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_LOOKUP,    1'b0, 16'd0,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_LOOKUP,    1'b1, 16'h8000, 32'd0,      24'd0,        1'b0);
        add_cmd(0, MODE_UNINSTALL, 1'b0, ID_MAX, 32'd0,        24'd0,        1'b1);
        add_cmd(0, MODE_UNINSTALL, 1'b0, 16'd0,  32'd0,        24'd0,        1'b1);
        add_cmd(0, MODE_UNINSTALL, 1'b1, 16'd0,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_UNINSTALL, 1'b1, 16'd1,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_LOOKUP,    1'b1, 16'd1,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_ALIAS,     1'b1, 16'd0,  32'd0,        24'd0,        1'b0);
        add_cmd(0, MODE_INSTALL,   1'b1, 16'h5555, 32'd0,      24'haaaaaa,   1'b0);
        add_cmd(0, MODE_UNINSTALL, 1'b0, ID_MAX, 32'd0,        24'd0,        1'b0);

        // random phases: fill up to full, mixed, drain, and a small key set
        for (ph = 0; ph < 16; ph++) begin
            no_idle  = (ph % 5 == 3);
            kind_sel = (ph < 2) ? 0 : ph % 4;
            for (n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                case (kind_sel)
                    0: begin
                        mode = (r < 85) ? MODE_INSTALL : (r < 92) ? MODE_LOOKUP :
                               (r < 98) ? MODE_UNINSTALL : MODE_ALIAS;
                    end
                    2: begin
                        mode = (r < 20) ? MODE_INSTALL : (r < 30) ? MODE_LOOKUP :
                               (r < 97) ? MODE_UNINSTALL : MODE_ALIAS;
                    end
                    default: begin
                        mode = (r < 40) ? MODE_INSTALL : (r < 65) ? MODE_LOOKUP :
                               (r < 95) ? MODE_UNINSTALL : MODE_ALIAS;
                    end
                endcase
                q = $urandom_range(0, 99);
                if (q < 3) begin
                    id   = '0;
                    kind = 1'($urandom_range(0, 1));
                end else if (q < 10) begin
                    id   = ID_W'($urandom);
                    kind = 1'($urandom_range(0, 1));
                end else begin
                    idx  = (kind_sel == 3) ? $urandom_range(0, 7)
                                           : $urandom_range(0, POOL_SIZE - 1);
                    id   = pool_id[idx];
                    kind = pool_kind[idx];
                end
                q = $urandom_range(0, 99);
                handle = (q < 5) ? '0 : (q < 10) ? '1 : $urandom;
                q = $urandom_range(0, 99);
                len = (q < 5) ? '0 : (q < 10) ? '1 : LEN_W'($urandom);
                add_cmd(n == 0, mode, kind, id, handle, len, $urandom_range(0, 3) == 0);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            if (cmd_q.size() == 0 && !start && reply_q.size() == 0) break;
        end
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
src/srt_pkg.sv
src/srt_cell.sv
src/sorted_resource_table.sv
tb/tb_sorted_resource_table.sv
